// ===== hw/rtl/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// scm_pkg: shared types and constants for the scalar color mapper
// Fixed-point formats, register codes and the divider cell payload.
// ----------------------------------------------------------------------------
package scm_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 12;
  localparam int MAX_BANDS = 256;
  localparam int ONE       = 1 << FRAC_BITS;

  // field widths
  localparam int SMP_W  = 16;
  localparam int OUT_W  = FRAC_BITS + 1;
  localparam int BAND_W = 9;
  localparam int PAL_W  = 2;
  localparam int IDX_W  = 3;
  localparam int DAT_W  = 16;

  // divider widths: band count, remainder, quotient, dividend
  localparam int NB_W = $clog2(MAX_BANDS) + 1;
  localparam int R_W  = NB_W + 1;
  localparam int Q_W  = SMP_W;
  localparam int KM_W = SMP_W + NB_W - FRAC_BITS;
  localparam int D_W  = KM_W + FRAC_BITS;
  localparam int RI_W = D_W - Q_W;

  // rainbow channel value (ten times the channel) and the divide by ten
  localparam int C_W       = $clog2(10 * ONE + 1);
  localparam int X_W       = C_W + 1;
  localparam int DIV10_MUL = 52429;
  localparam int DIV10_SH  = 19;
  localparam int M_W       = 16;
  localparam int P_W       = X_W + M_W;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SCALING  = 3'd0,
    REG_CLAMP_LO = 3'd1,
    REG_CLAMP_HI = 3'd2,
    REG_SMOOTH   = 3'd3,
    REG_BANDS    = 3'd4,
    REG_PALETTE  = 3'd5,
    REG_SLICE    = 3'd6
  } reg_idx_t;

  // palette codes
  typedef enum logic [PAL_W-1:0] {
    PAL_GRAY    = 2'd0,
    PAL_RAINBOW = 2'd1,
    PAL_RED     = 2'd2
  } pal_t;

  // payload handed from cell to cell along the divider chain
  typedef struct packed {
    logic signed [SMP_W-1:0] vs;
    logic                    neg;
    logic [R_W-1:0]          rem;
    logic [Q_W-1:0]          low;
    logic [Q_W-1:0]          quo;
  } div_t;

endpackage

// ===== hw/rtl/scm_if.sv =====
// ----------------------------------------------------------------------------
// scm_if: channel interfaces of the scalar color mapper
// Sample input, color output and register write channels.
// ----------------------------------------------------------------------------
interface scm_in_if import scm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface scm_out_if import scm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red;
  logic [OUT_W-1:0] green;
  logic [OUT_W-1:0] blue;
  logic [OUT_W-1:0] alpha;
  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

interface scm_cfg_if import scm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/scm_front.sv =====
// ----------------------------------------------------------------------------
// scm_front: window clamp and band index
// Clamps the sample unless scaling is set, then forms the truncated band
// index and loads the first remainder of the division chain.
// ----------------------------------------------------------------------------
module scm_front import scm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] sample,
  input  logic                    scaling,
  input  logic signed [SMP_W-1:0] clamp_lo,
  input  logic signed [SMP_W-1:0] clamp_hi,
  input  logic [NB_W-1:0]         bands,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output div_t                    dn_data
);

  logic                    v1_r, v2_r;
  logic                    rdy1, rdy2;
  logic signed [SMP_W-1:0] vc_r, vc_nxt;
  div_t                    d_r, d_nxt;
  logic [SMP_W-1:0]        mag;
  logic [SMP_W+NB_W-1:0]   prod;
  logic [KM_W-1:0]         kmag;
  logic [D_W-1:0]          dvd;

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // clamp unless scaling is set, low bound tested first
  always_comb begin
    vc_nxt = sample;
    if (!scaling) begin
      if (sample < clamp_lo) vc_nxt = clamp_lo;
      else if (sample > clamp_hi) vc_nxt = clamp_hi;
    end
  end

  // band index magnitude, truncated toward zero, and initial remainder
  always_comb begin
    mag  = vc_r[SMP_W-1] ? SMP_W'(-vc_r) : SMP_W'(vc_r);
    prod = mag * bands;
    kmag = prod[SMP_W+NB_W-1:FRAC_BITS];
    dvd  = {kmag, {FRAC_BITS{1'b0}}};
    d_nxt.vs  = vc_r;
    d_nxt.neg = vc_r[SMP_W-1];
    d_nxt.rem = R_W'(dvd[D_W-1:Q_W]);
    d_nxt.low = dvd[Q_W-1:0];
    d_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) vc_r <= vc_nxt;
    if (rdy2 && v1_r) d_r <= d_nxt;
  end

  assign dn_valid = v2_r;
  assign dn_data  = d_r;

endmodule

// ===== hw/rtl/scm_div_cell.sv =====
// ----------------------------------------------------------------------------
// scm_div_cell: one restoring division step
// Shifts one dividend bit into the remainder, develops one quotient bit
// and hands the item to the next cell.
// ----------------------------------------------------------------------------
module scm_div_cell import scm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [NB_W-1:0] bands,
  input  logic            up_valid,
  output logic            up_ready,
  input  div_t            up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output div_t            dn_data
);

  logic           valid_r;
  div_t           d_r, d_nxt;
  logic [R_W-1:0] trial;
  logic           ge;

  assign up_ready = !valid_r || dn_ready;

  // trial subtract of the band count
  always_comb begin
    trial     = {up_data.rem[R_W-2:0], up_data.low[Q_W-1]};
    ge        = trial >= R_W'(bands);
    d_nxt     = up_data;
    d_nxt.rem = ge ? trial - R_W'(bands) : trial;
    d_nxt.low = {up_data.low[Q_W-2:0], 1'b0};
    d_nxt.quo = {up_data.quo[Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) d_r <= d_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = d_r;

endmodule

// ===== hw/rtl/scm_color.sv =====
// ----------------------------------------------------------------------------
// scm_color: palette lookup
// Picks the band value, evaluates the palettes and alpha, and divides the
// rainbow channels by ten through a reciprocal multiply.
// ----------------------------------------------------------------------------
module scm_color import scm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             smooth,
  input  logic             slice,
  input  logic [PAL_W-1:0] palette,
  input  logic             up_valid,
  output logic             up_ready,
  input  div_t             up_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] red,
  output logic [OUT_W-1:0] green,
  output logic [OUT_W-1:0] blue,
  output logic [OUT_W-1:0] alpha
);

  localparam int V_W = SMP_W + 1;

  logic             v1_r, v2_r, v3_r;
  logic             rdy1, rdy2, rdy3;
  logic signed [V_W-1:0] qs, vfin;
  int               w5;
  logic [OUT_W-1:0] sat_nxt, sat_r, sat2_r, alpha_nxt, alpha_r, alpha2_r;
  logic [C_W-1:0]   c10_nxt [3];
  logic [C_W-1:0]   c10_r   [3];
  logic [P_W-1:0]   prod_r  [3];
  logic [OUT_W-1:0] ch      [3];
  logic [OUT_W-1:0] red_r, green_r, blue_r, alpha_out_r;
  logic [OUT_W-1:0] red_nxt, green_nxt, blue_nxt;

  // ten times one rainbow channel, limited to 0..10
  function automatic logic [C_W-1:0] chan(input int w, input int a, input int p,
                                          input int q);
    int d1, d2, c;
    d1 = w - p * ONE;
    d2 = w - q * ONE;
    if (d1 < 0) d1 = -d1;
    if (d2 < 0) d2 = -d2;
    c = a * ONE - 2 * d1 - d2;
    if (c < 0) c = 0;
    if (c > 10 * ONE) c = 10 * ONE;
    return C_W'(c);
  endfunction

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // band value with sign restored, palette terms
  always_comb begin
    qs   = V_W'(signed'({1'b0, up_data.quo}));
    vfin = smooth ? V_W'(up_data.vs) : (up_data.neg ? -qs : qs);
    if (vfin < 0) sat_nxt = '0;
    else if (vfin > V_W'(ONE)) sat_nxt = OUT_W'(ONE);
    else sat_nxt = OUT_W'(vfin);
    alpha_nxt  = slice ? sat_nxt : OUT_W'(ONE);
    w5         = 22 * int'(vfin) + 4 * ONE;
    c10_nxt[0] = chan(w5, 30, 20, 25);
    c10_nxt[1] = chan(w5, 40, 10, 20);
    c10_nxt[2] = chan(w5, 30, 5, 10);
  end

  // divide by ten, rounding half up
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch[i] = OUT_W'(prod_r[i] >> DIV10_SH);
    end
  end

  // palette select
  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    case (palette)
      PAL_GRAY: begin
        red_nxt   = sat2_r;
        green_nxt = sat2_r;
        blue_nxt  = sat2_r;
      end
      PAL_RAINBOW: begin
        red_nxt   = ch[0];
        green_nxt = ch[1];
        blue_nxt  = ch[2];
      end
      PAL_RED: begin
        red_nxt   = OUT_W'(ONE);
        green_nxt = sat2_r;
        blue_nxt  = sat2_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      sat_r   <= sat_nxt;
      alpha_r <= alpha_nxt;
      c10_r   <= c10_nxt;
    end
    if (rdy2 && v1_r) begin
      sat2_r   <= sat_r;
      alpha2_r <= alpha_r;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= (X_W'(c10_r[i]) + X_W'(5)) * M_W'(DIV10_MUL);
      end
    end
    if (rdy3 && v2_r) begin
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
      alpha_out_r <= alpha2_r;
    end
  end

  assign out_valid = v3_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign alpha     = alpha_out_r;

endmodule

// ===== hw/rtl/scalar_color_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// scalar_color_mapper_unit: banded scalar to RGBA color mapper
// Two front stages, one divider cell per quotient bit, three palette
// stages. Throughput one item per cycle when the output is not stalled;
// every stage has its own valid and back-pressure. Synchronous active-low
// reset empties the pipe and loads the register reset values.
// ----------------------------------------------------------------------------
module scalar_color_mapper_unit import scm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  scm_in_if.sink   in_if,
  scm_out_if.source out_if,
  scm_cfg_if.sink  cfg_if
);

  logic                    scaling_r, smooth_r, slice_r;
  logic signed [SMP_W-1:0] clamp_lo_r, clamp_hi_r;
  logic [BAND_W-1:0]       bands_r;
  logic [PAL_W-1:0]        palette_r;
  logic [NB_W-1:0]         bands_eff;

  logic                    cv [Q_W+1];
  logic                    cr [Q_W+1];
  div_t                    cd [Q_W+1];

  // register writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scaling_r  <= 1'b0;
      clamp_lo_r <= '0;
      clamp_hi_r <= SMP_W'(ONE);
      smooth_r   <= 1'b1;
      bands_r    <= BAND_W'(8);
      palette_r  <= PAL_RAINBOW;
      slice_r    <= 1'b0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_SCALING:  scaling_r  <= cfg_if.data[0];
        REG_CLAMP_LO: clamp_lo_r <= cfg_if.data[SMP_W-1:0];
        REG_CLAMP_HI: clamp_hi_r <= cfg_if.data[SMP_W-1:0];
        REG_SMOOTH:   smooth_r   <= cfg_if.data[0];
        REG_BANDS:    bands_r    <= cfg_if.data[BAND_W-1:0];
        REG_PALETTE:  palette_r  <= cfg_if.data[PAL_W-1:0];
        REG_SLICE:    slice_r    <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // band count limited to 1..MAX_BANDS
  always_comb begin
    if (bands_r == '0) bands_eff = NB_W'(1);
    else if (32'(bands_r) > MAX_BANDS) bands_eff = NB_W'(MAX_BANDS);
    else bands_eff = NB_W'(bands_r);
  end

  scm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sample   (in_if.sample),
    .scaling  (scaling_r),
    .clamp_lo (clamp_lo_r),
    .clamp_hi (clamp_hi_r),
    .bands    (bands_eff),
    .dn_valid (cv[0]),
    .dn_ready (cr[0]),
    .dn_data  (cd[0])
  );

  // division chain, one quotient bit per cell
  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    scm_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bands    (bands_eff),
      .up_valid (cv[i]),
      .up_ready (cr[i]),
      .up_data  (cd[i]),
      .dn_valid (cv[i+1]),
      .dn_ready (cr[i+1]),
      .dn_data  (cd[i+1])
    );
  end

  scm_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .smooth    (smooth_r),
    .slice     (slice_r),
    .palette   (palette_r),
    .up_valid  (cv[Q_W]),
    .up_ready  (cr[Q_W]),
    .up_data   (cd[Q_W]),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .red       (out_if.red),
    .green     (out_if.green),
    .blue      (out_if.blue),
    .alpha     (out_if.alpha)
  );

  // checks
  a_chain_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cv[Q_W] |-> cd[Q_W].rem < R_W'(bands_eff))
    else $error("remainder not below band count at end of chain");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.red <= OUT_W'(ONE) && out_if.green <= OUT_W'(ONE)
                      && out_if.blue <= OUT_W'(ONE) && out_if.alpha <= OUT_W'(ONE)))
    else $error("color channel above one");

  a_red_pal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && palette_r == PAL_RED) |-> out_if.red == OUT_W'(ONE))
    else $error("red-white palette without full red");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !slice_r) |-> out_if.alpha == OUT_W'(ONE))
    else $error("alpha not one with slice alpha off");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_if.valid && bands_r == BAND_W'(8) && smooth_r))
    else $error("reset state not loaded");

endmodule
